// ===== rtl/xmov_pkg.sv =====
`timescale 1ns / 1ps

package xmov_pkg;

    localparam int MaxLen     = 7;
    localparam int QueueDepth = 2;

    typedef enum logic [1:0] {
        KIND_REG_REG = 2'd0,
        KIND_LOAD    = 2'd1,
        KIND_STORE   = 2'd2,
        KIND_IMM_REG = 2'd3
    } kind_t;

    localparam logic [1:0] DISP_NONE = 2'd0;
    localparam logic [1:0] DISP_8    = 2'd1;
    localparam logic [1:0] DISP_32   = 2'd2;
    localparam logic [1:0] DISP_RSVD = 2'd3;

    localparam logic [2:0] REG_EAX = 3'd0;
    localparam logic [2:0] REG_ESP = 3'd4;
    localparam logic [2:0] REG_EBP = 3'd5;

    localparam logic [1:0] MOD_NONE = 2'd0;
    localparam logic [1:0] MOD_D8   = 2'd1;
    localparam logic [1:0] MOD_D32  = 2'd2;
    localparam logic [1:0] MOD_REG  = 2'd3;

    localparam logic [7:0] OP_MOV_LOAD  = 8'h8B;
    localparam logic [7:0] OP_MOV_STORE = 8'h89;
    localparam logic [7:0] OP_MOFFS_LD  = 8'hA1;
    localparam logic [7:0] OP_MOFFS_ST  = 8'hA3;
    localparam logic [7:0] OP_MOV_IMM   = 8'hB8;
    localparam logic [7:0] SIB_ESP_ONLY = 8'h24;

    typedef struct packed {
        logic [MaxLen-1:0][7:0] bytes;
        logic [2:0]             len;
        logic                   invalid;
    } enc_item_t;

    typedef struct packed {
        logic valid;
        logic ready;
    } q_hs_t;

endpackage

// ===== rtl/xmov_front.sv =====
`timescale 1ns / 1ps

module xmov_front (
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           kind,
    input  logic [2:0]           reg_operand,
    input  logic [2:0]           source_reg,
    input  logic                 has_base,
    input  logic [2:0]           base_reg,
    input  logic                 has_index,
    input  logic [2:0]           index_reg,
    input  logic [1:0]           scale_log,
    input  logic [1:0]           disp_size,
    input  logic [31:0]          disp_value,
    output xmov_pkg::q_hs_t      wr_hs,
    input  logic                 q_ready,
    output xmov_pkg::enc_item_t  wr_item
);

    logic       disp_only;
    logic       bad;
    logic       need_sib;
    logic [1:0] mode;
    logic [2:0] pos;

    assign in_ready    = q_ready;
    assign wr_hs.valid = in_valid;
    assign wr_hs.ready = q_ready;

    always_comb
    begin
        wr_item   = '0;
        disp_only = !has_base && !has_index && (disp_size == xmov_pkg::DISP_32);
        bad       = 1'b0;
        need_sib  = has_index || (base_reg == xmov_pkg::REG_ESP);
        mode      = disp_size;
        pos       = 3'd2;
        if ((disp_size == xmov_pkg::DISP_NONE) && (base_reg == xmov_pkg::REG_EBP))
        begin
            mode = xmov_pkg::MOD_D8;
        end
        case (xmov_pkg::kind_t'(kind))
            xmov_pkg::KIND_REG_REG:
            begin
                wr_item.bytes[0] = xmov_pkg::OP_MOV_LOAD;
                wr_item.bytes[1] = {xmov_pkg::MOD_REG, reg_operand, source_reg};
                wr_item.len      = 3'd2;
            end
            xmov_pkg::KIND_IMM_REG:
            begin
                wr_item.bytes[0] = xmov_pkg::OP_MOV_IMM | {5'd0, reg_operand};
                wr_item.bytes[1] = disp_value[7:0];
                wr_item.bytes[2] = disp_value[15:8];
                wr_item.bytes[3] = disp_value[23:16];
                wr_item.bytes[4] = disp_value[31:24];
                wr_item.len      = 3'd5;
            end
            default:
            begin
                if ((reg_operand == xmov_pkg::REG_EAX) && disp_only)
                begin
                    wr_item.bytes[0] = (kind == xmov_pkg::KIND_LOAD) ?
                                       xmov_pkg::OP_MOFFS_LD : xmov_pkg::OP_MOFFS_ST;
                    wr_item.bytes[1] = disp_value[7:0];
                    wr_item.bytes[2] = disp_value[15:8];
                    wr_item.bytes[3] = disp_value[23:16];
                    wr_item.bytes[4] = disp_value[31:24];
                    wr_item.len      = 3'd5;
                end
                else
                begin
                    wr_item.bytes[0] = (kind == xmov_pkg::KIND_LOAD) ?
                                       xmov_pkg::OP_MOV_LOAD : xmov_pkg::OP_MOV_STORE;
                    bad = (disp_size == xmov_pkg::DISP_RSVD)
                        || (has_index && ((index_reg == xmov_pkg::REG_ESP) || !has_base))
                        || (!has_index && (scale_log != 2'd0))
                        || (!has_base && !has_index && (disp_size != xmov_pkg::DISP_32));
                    if (!has_base && !has_index)
                    begin
                        wr_item.bytes[1] = {xmov_pkg::MOD_NONE, reg_operand,
                                            xmov_pkg::REG_EBP};
                        wr_item.bytes[2] = disp_value[7:0];
                        wr_item.bytes[3] = disp_value[15:8];
                        wr_item.bytes[4] = disp_value[23:16];
                        wr_item.bytes[5] = disp_value[31:24];
                        wr_item.len      = 3'd6;
                    end
                    else
                    begin
                        wr_item.bytes[1] = {mode, reg_operand,
                                            need_sib ? xmov_pkg::REG_ESP : base_reg};
                        if (need_sib)
                        begin
                            wr_item.bytes[2] = has_index ?
                                               {scale_log, index_reg, base_reg} :
                                               xmov_pkg::SIB_ESP_ONLY;
                            pos = 3'd3;
                        end
                        if (mode == xmov_pkg::MOD_D8)
                        begin
                            wr_item.bytes[pos] = (disp_size == xmov_pkg::DISP_8) ?
                                                 disp_value[7:0] : 8'h00;
                            wr_item.len        = pos + 3'd1;
                        end
                        else if (mode == xmov_pkg::MOD_D32)
                        begin
                            wr_item.bytes[pos]        = disp_value[7:0];
                            wr_item.bytes[pos + 3'd1] = disp_value[15:8];
                            wr_item.bytes[pos + 3'd2] = disp_value[23:16];
                            wr_item.bytes[pos + 3'd3] = disp_value[31:24];
                            wr_item.len               = pos + 3'd4;
                        end
                        else
                        begin
                            wr_item.len = pos;
                        end
                    end
                    if (bad)
                    begin
                        wr_item         = '0;
                        wr_item.len     = 3'd1;
                        wr_item.invalid = 1'b1;
                    end
                end
            end
        endcase
    end

endmodule

// ===== rtl/xmov_queue.sv =====
`timescale 1ns / 1ps

module xmov_queue #(
    parameter int DEPTH = xmov_pkg::QueueDepth
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  xmov_pkg::q_hs_t      wr_hs,
    input  xmov_pkg::enc_item_t  wr_item,
    output logic                 wr_ready,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output xmov_pkg::enc_item_t  rd_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);

    xmov_pkg::enc_item_t mem [DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;
    logic          push, pop;

    assign wr_ready = (count_reg != CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem[rd_ptr_reg];
    assign push     = wr_hs.valid && wr_hs.ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ===== rtl/xmov_back.sv =====
`timescale 1ns / 1ps

module xmov_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [31:0]          start_address,
    input  logic                 rd_valid,
    output logic                 rd_ready,
    input  xmov_pkg::enc_item_t  rd_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           code_byte,
    output logic [31:0]          byte_address,
    output logic                 last,
    output logic                 invalid
);

    xmov_pkg::enc_item_t cur_reg, cur_next;
    logic                busy_reg, busy_next;
    logic [2:0]          cnt_reg, cnt_next;
    logic [31:0]         offset_reg, offset_next;
    logic                fire, done;

    assign out_valid    = busy_reg;
    assign code_byte    = cur_reg.bytes[cnt_reg];
    assign byte_address = start_address + offset_reg;
    assign last         = (cnt_reg == (cur_reg.len - 3'd1));
    assign invalid      = cur_reg.invalid;
    assign fire         = busy_reg && out_ready;
    assign done         = fire && last;
    assign rd_ready     = !busy_reg || done;

    always_comb
    begin
        cur_next    = cur_reg;
        busy_next   = busy_reg;
        cnt_next    = cnt_reg;
        offset_next = offset_reg;
        if (fire)
        begin
            cnt_next = cnt_reg + 3'd1;
            if (!cur_reg.invalid)
            begin
                offset_next = offset_reg + 32'd1;
            end
        end
        if (done)
        begin
            busy_next = 1'b0;
        end
        if (rd_valid && rd_ready)
        begin
            cur_next  = rd_item;
            busy_next = 1'b1;
            cnt_next  = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            cnt_reg    <= 3'd0;
            offset_reg <= 32'd0;
        end
        else
        begin
            busy_reg   <= busy_next;
            cnt_reg    <= cnt_next;
            offset_reg <= offset_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

endmodule

// ===== rtl/x86_mov_instruction_encoder_unit.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    one MOV request
// out       output     out_valid / out_ready  one code byte, address, last, invalid
// cfg       input      cfg_we / cfg_wdata     start_address
//
// A request is encoded in the cycle it is taken and queued; the back end emits
// one byte per cycle while out_ready is high; an instruction has 1 to 7 bytes.
// Requests enter back to back while the queue has room. Reset clears the queue,
// the byte counter and the running offset. A stall at out holds the current
// byte; a full queue drops in_ready.

module x86_mov_instruction_encoder_unit #(
    parameter int QUEUE_DEPTH = xmov_pkg::QueueDepth
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [2:0]  reg_operand,
    input  logic [2:0]  source_reg,
    input  logic        has_base,
    input  logic [2:0]  base_reg,
    input  logic        has_index,
    input  logic [2:0]  index_reg,
    input  logic [1:0]  scale_log,
    input  logic [1:0]  disp_size,
    input  logic [31:0] disp_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  code_byte,
    output logic [31:0] byte_address,
    output logic        last,
    output logic        invalid
);

    logic [31:0]         start_address_reg;
    xmov_pkg::q_hs_t     wr_hs;
    xmov_pkg::enc_item_t wr_item;
    xmov_pkg::enc_item_t rd_item;
    logic                q_ready;
    logic                rd_valid;
    logic                rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_address_reg <= 32'd0;
        end
        else if (cfg_we)
        begin
            start_address_reg <= cfg_wdata;
        end
    end

    xmov_front u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .reg_operand (reg_operand),
        .source_reg  (source_reg),
        .has_base    (has_base),
        .base_reg    (base_reg),
        .has_index   (has_index),
        .index_reg   (index_reg),
        .scale_log   (scale_log),
        .disp_size   (disp_size),
        .disp_value  (disp_value),
        .wr_hs       (wr_hs),
        .q_ready     (q_ready),
        .wr_item     (wr_item)
    );

    xmov_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_hs    (wr_hs),
        .wr_item  (wr_item),
        .wr_ready (q_ready),
        .rd_valid (rd_valid),
        .rd_ready (rd_ready),
        .rd_item  (rd_item)
    );

    xmov_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .start_address (start_address_reg),
        .rd_valid      (rd_valid),
        .rd_ready      (rd_ready),
        .rd_item       (rd_item),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .code_byte     (code_byte),
        .byte_address  (byte_address),
        .last          (last),
        .invalid       (invalid)
    );

endmodule
